// ----- sv/utf8v_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_pkg
// shared types and constants for the utf-8 stream checker
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int POS_BITS  = 32;
    localparam int OUT_BITS  = 32;
    localparam int N_CLASSES = 6;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [2:0] t_cls;

    localparam t_cls CLS_ASCII   = 3'd0;
    localparam t_cls CLS_CONT    = 3'd1;
    localparam t_cls CLS_LEAD2   = 3'd2;
    localparam t_cls CLS_LEAD3   = 3'd3;
    localparam t_cls CLS_LEAD4   = 3'd4;
    localparam t_cls CLS_INVALID = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        t_cls       cls;
        logic       last;
    } t_item;

endpackage

// ----- sv/utf8v_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_front
// sorts each incoming byte into its utf-8 class and forms a queue entry
// ----------------------------------------------------------------------------
module utf8v_front (
    input  logic [7:0]      i_data_byte,
    input  logic            i_last,
    output utf8v_pkg::t_item o_item
);
    import utf8v_pkg::*;

    localparam logic [7:0] B_C2 = 8'hC2;
    localparam logic [7:0] B_DF = 8'hDF;
    localparam logic [7:0] B_E0 = 8'hE0;
    localparam logic [7:0] B_EF = 8'hEF;
    localparam logic [7:0] B_F0 = 8'hF0;
    localparam logic [7:0] B_F4 = 8'hF4;

    t_cls w_cls;

    always_comb begin
        priority if (!i_data_byte[7]) begin
            w_cls = CLS_ASCII;
        end else if (i_data_byte[7:6] == 2'b10) begin
            w_cls = CLS_CONT;
        end else if (i_data_byte >= B_C2 && i_data_byte <= B_DF) begin
            w_cls = CLS_LEAD2;
        end else if (i_data_byte >= B_E0 && i_data_byte <= B_EF) begin
            w_cls = CLS_LEAD3;
        end else if (i_data_byte >= B_F0 && i_data_byte <= B_F4) begin
            w_cls = CLS_LEAD4;
        end else begin
            w_cls = CLS_INVALID;
        end
    end

    assign o_item.data_byte = i_data_byte;
    assign o_item.cls       = w_cls;
    assign o_item.last      = i_last;

endmodule

// ----- sv/utf8v_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_queue
// two-entry queue between the classifier and the checker
// ----------------------------------------------------------------------------
module utf8v_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utf8v_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nonempty,
    output utf8v_pkg::t_item o_item
);
    import utf8v_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_item                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;

    assign o_full     = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/utf8v_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_back
// class counters, sequence checker and result register
// ----------------------------------------------------------------------------
module utf8v_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_nonempty,
    input  utf8v_pkg::t_item               i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_ascii_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_continuation_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_leader2_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_leader3_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_leader4_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_invalid_count,
    output logic                           o_stream_valid,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_first_error_pos
);
    import utf8v_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [POS_BITS-1:0]   POS_MAX = '1;
    localparam logic [7:0] B_E0 = 8'hE0;
    localparam logic [7:0] B_ED = 8'hED;
    localparam logic [7:0] B_F0 = 8'hF0;
    localparam logic [7:0] B_F4 = 8'hF4;
    localparam logic [7:0] B_A0 = 8'hA0;
    localparam logic [7:0] B_9F = 8'h9F;
    localparam logic [7:0] B_90 = 8'h90;
    localparam logic [7:0] B_8F = 8'h8F;

    logic [COUNT_BITS-1:0] r_counts [N_CLASSES];
    logic [COUNT_BITS-1:0] n_counts [N_CLASSES];
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [1:0]            r_rem, n_rem;
    logic [1:0]            r_seq_off, n_seq_off;
    logic [7:0]            r_lead, n_lead;
    logic [POS_BITS-1:0]   r_lead_pos, n_lead_pos;
    logic                  r_range, n_range;
    logic                  r_bad, n_bad;
    logic [POS_BITS-1:0]   r_bad_pos, n_bad_pos;
    logic                  r_err, n_err;
    logic [POS_BITS-1:0]   r_err_pos, n_err_pos;

    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_counts [N_CLASSES];
    logic [OUT_BITS-1:0]   n_out_counts [N_CLASSES];
    logic                  r_out_ok;
    logic [OUT_BITS-1:0]   r_out_err_pos;

    logic                  w_range_hit;

    assign o_pop = i_nonempty && (!i_item.last || !r_out_valid || i_ready);

    assign w_range_hit = (r_lead == B_E0 && i_item.data_byte < B_A0) ||
                         (r_lead == B_ED && i_item.data_byte > B_9F) ||
                         (r_lead == B_F0 && i_item.data_byte < B_90) ||
                         (r_lead == B_F4 && i_item.data_byte > B_8F);

    always_comb begin
        for (int k = 0; k < N_CLASSES; k++) begin
            n_counts[k] = r_counts[k];
            if (i_item.cls == t_cls'(k) && r_counts[k] != CNT_MAX) begin
                n_counts[k] = r_counts[k] + 1'b1;
            end
        end
        n_pos      = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
        n_rem      = r_rem;
        n_seq_off  = r_seq_off;
        n_lead     = r_lead;
        n_lead_pos = r_lead_pos;
        n_range    = r_range;
        n_bad      = r_bad;
        n_bad_pos  = r_bad_pos;
        n_err      = r_err;
        n_err_pos  = r_err_pos;

        if (!r_err) begin
            if (r_rem != 2'd0) begin
                if (r_seq_off == 2'd1 && w_range_hit) begin
                    n_range = 1'b1;
                end
                if (!r_bad && i_item.cls != CLS_CONT) begin
                    n_bad     = 1'b1;
                    n_bad_pos = r_pos;
                end
                n_rem     = r_rem - 1'b1;
                n_seq_off = r_seq_off + 1'b1;
                if (n_rem == 2'd0) begin
                    if (n_bad) begin
                        n_err     = 1'b1;
                        n_err_pos = n_bad_pos;
                    end else if (n_range) begin
                        n_err     = 1'b1;
                        n_err_pos = r_lead_pos;
                    end
                    n_seq_off = 2'd0;
                end
            end else if (i_item.cls == CLS_CONT || i_item.cls == CLS_INVALID) begin
                n_err     = 1'b1;
                n_err_pos = r_pos;
            end else if (i_item.cls != CLS_ASCII) begin
                n_rem      = 2'(i_item.cls - 3'd1);
                n_seq_off  = 2'd1;
                n_lead     = i_item.data_byte;
                n_lead_pos = r_pos;
                n_range    = 1'b0;
                n_bad      = 1'b0;
                n_bad_pos  = '0;
            end
            if (i_item.last && n_rem != 2'd0 && !n_err) begin
                n_err     = 1'b1;
                n_err_pos = n_lead_pos;
            end
        end

        for (int k = 0; k < N_CLASSES; k++) begin
            if (COUNT_BITS > OUT_BITS && n_counts[k] > COUNT_BITS'({OUT_BITS{1'b1}})) begin
                n_out_counts[k] = '1;
            end else begin
                n_out_counts[k] = OUT_BITS'(n_counts[k]);
            end
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_item.last)) begin
            for (int k = 0; k < N_CLASSES; k++) begin
                r_counts[k] <= '0;
            end
            r_pos      <= '0;
            r_rem      <= '0;
            r_seq_off  <= '0;
            r_lead     <= '0;
            r_lead_pos <= '0;
            r_range    <= 1'b0;
            r_bad      <= 1'b0;
            r_bad_pos  <= '0;
            r_err      <= 1'b0;
            r_err_pos  <= '0;
        end else if (o_pop) begin
            r_counts   <= n_counts;
            r_pos      <= n_pos;
            r_rem      <= n_rem;
            r_seq_off  <= n_seq_off;
            r_lead     <= n_lead;
            r_lead_pos <= n_lead_pos;
            r_range    <= n_range;
            r_bad      <= n_bad;
            r_bad_pos  <= n_bad_pos;
            r_err      <= n_err;
            r_err_pos  <= n_err_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_counts  <= n_out_counts;
            r_out_ok      <= !n_err;
            r_out_err_pos <= n_err ? OUT_BITS'(n_err_pos) : '0;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_ascii_count        = r_out_counts[CLS_ASCII];
    assign o_continuation_count = r_out_counts[CLS_CONT];
    assign o_leader2_count      = r_out_counts[CLS_LEAD2];
    assign o_leader3_count      = r_out_counts[CLS_LEAD3];
    assign o_leader4_count      = r_out_counts[CLS_LEAD4];
    assign o_invalid_count      = r_out_counts[CLS_INVALID];
    assign o_stream_valid       = r_out_ok;
    assign o_first_error_pos    = r_out_err_pos;

endmodule

// ----- sv/utf8_stream_validator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// utf-8 stream checker: class counts and first structural error per stream
// ----------------------------------------------------------------------------
// throughput: one byte per cycle unless a held result stalls a final byte
// result path: a stream's final byte is written into the queue, then the checker
//   updates the result register, which presents the result for that stream
// stalls: a final byte waits in the queue while an unaccepted result is held
// reset: i_rst_n synchronous active low; empties the queue, clears all
//   counters and sequence state, and drops o_valid
module utf8_stream_validator_top #(
    parameter int COUNT_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_ascii_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_continuation_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_leader2_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_leader3_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_leader4_count,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_invalid_count,
    output logic                           o_stream_valid,
    output logic [utf8v_pkg::OUT_BITS-1:0] o_first_error_pos
);
    import utf8v_pkg::*;

    t_item w_in_item;
    t_item w_q_item;
    logic  w_full;
    logic  w_nonempty;
    logic  w_pop;

    assign o_ready = !w_full;

    utf8v_front u_front (
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_item      (w_in_item)
    );

    utf8v_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid && !w_full),
        .i_item     (w_in_item),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_item     (w_q_item)
    );

    utf8v_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_nonempty           (w_nonempty),
        .i_item               (w_q_item),
        .o_pop                (w_pop),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_ascii_count        (o_ascii_count),
        .o_continuation_count (o_continuation_count),
        .o_leader2_count      (o_leader2_count),
        .o_leader3_count      (o_leader3_count),
        .o_leader4_count      (o_leader4_count),
        .o_invalid_count      (o_invalid_count),
        .o_stream_valid       (o_stream_valid),
        .o_first_error_pos    (o_first_error_pos)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the utf-8 stream checker: a byte predictor builds
// the expected per-stream verdict, and each result transaction is compared
// field by field while both sides idle and stall in several phases
// ----------------------------------------------------------------------------
module tb_top;

    import utf8v_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_byte_item;

    typedef struct packed {
        logic [N_CLASSES-1:0][OUT_BITS-1:0] counts;
        logic                               ok;
        logic [OUT_BITS-1:0]                err_off;
    } t_verdict;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [7:0]          i_data_byte = 8'h00;
    logic                i_last = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [OUT_BITS-1:0] o_ascii_count;
    logic [OUT_BITS-1:0] o_continuation_count;
    logic [OUT_BITS-1:0] o_leader2_count;
    logic [OUT_BITS-1:0] o_leader3_count;
    logic [OUT_BITS-1:0] o_leader4_count;
    logic [OUT_BITS-1:0] o_invalid_count;
    logic                o_stream_valid;
    logic [OUT_BITS-1:0] o_first_error_pos;

    utf8_stream_validator_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_ascii_count       (o_ascii_count),
        .o_continuation_count(o_continuation_count),
        .o_leader2_count     (o_leader2_count),
        .o_leader3_count     (o_leader3_count),
        .o_leader4_count     (o_leader4_count),
        .o_invalid_count     (o_invalid_count),
        .o_stream_valid      (o_stream_valid),
        .o_first_error_pos   (o_first_error_pos)
    );

    always #4 i_clk = ~i_clk;

    t_byte_item byte_q[$];
    t_verdict   verdict_q[$];
    logic [7:0] sbuf[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_accepted = 0;
    int n_streams = 0;
    int n_bad_streams = 0;
    int n_fail = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // predictor state
    logic [OUT_BITS-1:0] cls_cnt [N_CLASSES];
    logic [POS_BITS-1:0] byte_pos;
    logic [1:0]          owed;
    logic [1:0]          seq_idx;
    logic [7:0]          lead;
    logic [POS_BITS-1:0] lead_pos;
    logic                range_bad;
    logic                cont_bad;
    logic [POS_BITS-1:0] cont_bad_pos;
    logic                err_seen;
    logic [POS_BITS-1:0] err_pos;

    function automatic t_cls classify(input logic [7:0] b);
        if (!b[7])                         return CLS_ASCII;
        if (b[7:6] == 2'b10)               return CLS_CONT;
        if (b >= 8'hC2 && b <= 8'hDF)      return CLS_LEAD2;
        if (b >= 8'hE0 && b <= 8'hEF)      return CLS_LEAD3;
        if (b >= 8'hF0 && b <= 8'hF4)      return CLS_LEAD4;
        return CLS_INVALID;
    endfunction

    task automatic clear_tracker();
        for (int k = 0; k < N_CLASSES; k++) cls_cnt[k] = '0;
        byte_pos = '0;
        owed = '0;
        seq_idx = '0;
        lead = '0;
        lead_pos = '0;
        range_bad = 1'b0;
        cont_bad = 1'b0;
        cont_bad_pos = '0;
        err_seen = 1'b0;
        err_pos = '0;
    endtask

    task automatic note_error(input logic [POS_BITS-1:0] p);
        if (!err_seen) begin
            err_seen = 1'b1;
            err_pos = p;
        end
    endtask

    task automatic track_byte(input logic [7:0] b, input logic is_last);
        t_cls                c;
        t_verdict            v;
        logic [POS_BITS-1:0] p;
        c = classify(b);
        p = byte_pos;
        if (cls_cnt[c] != '1) cls_cnt[c] = cls_cnt[c] + 1;
        if (!err_seen) begin
            if (owed != 0) begin
                if (seq_idx == 2'd1 && ((lead == 8'hE0 && b < 8'hA0) ||
                                        (lead == 8'hED && b > 8'h9F) ||
                                        (lead == 8'hF0 && b < 8'h90) ||
                                        (lead == 8'hF4 && b > 8'h8F)))
                    range_bad = 1'b1;
                if (!cont_bad && c != CLS_CONT) begin
                    cont_bad = 1'b1;
                    cont_bad_pos = p;
                end
                owed = owed - 2'd1;
                seq_idx = seq_idx + 2'd1;
                if (owed == 0) begin
                    if (cont_bad) note_error(cont_bad_pos);
                    else if (range_bad) note_error(lead_pos);
                    seq_idx = '0;
                end
            end else if (c == CLS_CONT || c == CLS_INVALID) begin
                note_error(p);
            end else if (c != CLS_ASCII) begin
                owed = 2'(c - 3'd1);
                seq_idx = 2'd1;
                lead = b;
                lead_pos = p;
                range_bad = 1'b0;
                cont_bad = 1'b0;
                cont_bad_pos = '0;
            end
            if (is_last && owed != 0) note_error(lead_pos);
        end
        if (byte_pos != '1) byte_pos = byte_pos + 1;
        if (is_last) begin
            for (int k = 0; k < N_CLASSES; k++) v.counts[k] = cls_cnt[k];
            v.ok = !err_seen;
            v.err_off = err_seen ? err_pos : '0;
            verdict_q.push_back(v);
            clear_tracker();
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // one character, mostly well formed; edge leaders are favoured
    task automatic add_char();
        int         kind;
        bit         at_edge;
        bit         loose;
        logic [7:0] ld;
        kind = $urandom_range(0, 9);
        at_edge = ($urandom_range(0, 2) == 0);
        loose = ($urandom_range(0, 6) == 0);
        if (kind <= 3) begin
            sbuf.push_back(8'($urandom_range(0, 127)));
        end else if (kind <= 5) begin
            sbuf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            sbuf.push_back(cont_byte());
        end else if (kind <= 7) begin
            ld = at_edge ? ($urandom_range(0, 1) ? 8'hE0 : 8'hED)
                         : 8'($urandom_range(8'hE0, 8'hEF));
            sbuf.push_back(ld);
            if (loose)             sbuf.push_back(cont_byte());
            else if (ld == 8'hE0)  sbuf.push_back(8'($urandom_range(8'hA0, 8'hBF)));
            else if (ld == 8'hED)  sbuf.push_back(8'($urandom_range(8'h80, 8'h9F)));
            else                   sbuf.push_back(cont_byte());
            sbuf.push_back(cont_byte());
        end else begin
            ld = at_edge ? ($urandom_range(0, 1) ? 8'hF0 : 8'hF4)
                         : 8'($urandom_range(8'hF0, 8'hF4));
            sbuf.push_back(ld);
            if (loose)             sbuf.push_back(cont_byte());
            else if (ld == 8'hF0)  sbuf.push_back(8'($urandom_range(8'h90, 8'hBF)));
            else if (ld == 8'hF4)  sbuf.push_back(8'($urandom_range(8'h80, 8'h8F)));
            else                   sbuf.push_back(cont_byte());
            sbuf.push_back(cont_byte());
            sbuf.push_back(cont_byte());
        end
    endtask

    task automatic push_stream();
        t_byte_item it;
        for (int i = 0; i < sbuf.size(); i++) begin
            it.data = sbuf[i];
            it.is_last = (i == sbuf.size() - 1);
            byte_q.push_back(it);
        end
    endtask

    task automatic gen_streams(input int n_bytes);
        int pushed;
        int mode;
        int n;
        pushed = 0;
        while (pushed < n_bytes) begin
            sbuf.delete();
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) add_char();
            mode = $urandom_range(0, 9);
            unique case (mode)
                6: begin
                    sbuf[$urandom_range(0, sbuf.size() - 1)] = 8'($urandom_range(0, 255));
                end
                7: begin
                    // open a sequence that the stream end may cut short
                    sbuf.push_back(8'($urandom_range(8'hC2, 8'hF4)));
                    if ($urandom_range(0, 1)) sbuf.push_back(8'($urandom_range(0, 255)));
                end
                8: begin
                    sbuf.insert($urandom_range(0, sbuf.size()), 8'($urandom_range(0, 255)));
                end
                9: begin
                    sbuf.delete();
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) sbuf.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            push_stream();
            pushed += sbuf.size();
        end
    endtask

    // driver: input transactions from the pending queue
    always @(posedge i_clk) begin
        t_byte_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                track_byte(i_data_byte, i_last);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || o_ready) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    it = byte_q.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= it.data;
                    i_last <= it.is_last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= 400) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [OUT_BITS-1:0] e,
                                 input logic [OUT_BITS-1:0] a);
        if (e !== a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            n_fail++;
        end
    endtask

    // monitor: result transactions against the oldest expected verdict
    always @(posedge i_clk) begin
        t_verdict v;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_streams++;
                if (o_stream_valid !== 1'b1) n_bad_streams++;
                if (verdict_q.size() == 0) begin
                    $error("result transaction with no expected verdict");
                    n_fail++;
                end else begin
                    v = verdict_q.pop_front();
                    compare_field("ascii_count", v.counts[CLS_ASCII], o_ascii_count);
                    compare_field("continuation_count", v.counts[CLS_CONT],
                                  o_continuation_count);
                    compare_field("leader2_count", v.counts[CLS_LEAD2], o_leader2_count);
                    compare_field("leader3_count", v.counts[CLS_LEAD3], o_leader3_count);
                    compare_field("leader4_count", v.counts[CLS_LEAD4], o_leader4_count);
                    compare_field("invalid_count", v.counts[CLS_INVALID], o_invalid_count);
                    compare_field("stream_valid", OUT_BITS'(v.ok), OUT_BITS'(o_stream_valid));
                    compare_field("first_error_pos", v.err_off, o_first_error_pos);
                end
            end
            i_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 75, 0, 25};
        recv_pct = '{0, 0, 75, 25};
        clear_tracker();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // valid mix of every length, starting with the extreme 00
        sbuf = '{8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        push_stream();
        sbuf = '{8'hFF};                       // stray invalid byte
        push_stream();
        sbuf = '{8'hE0, 8'h9F, 8'h80};         // overlong after e0
        push_stream();
        sbuf = '{8'hF4, 8'h90, 8'h80, 8'h80};  // above range after f4
        push_stream();
        sbuf = '{8'hED, 8'hA0, 8'h41};         // bad continuation beats range fault
        push_stream();
        sbuf = '{8'hF0, 8'h41};                // truncation beats bad continuation
        push_stream();
        sbuf = '{8'h80, 8'hC1, 8'h41};         // stray continuation, counting goes on
        push_stream();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            gen_streams(490);
            while (byte_q.size() != 0) @(negedge i_clk);
        end

        // last byte handed over and its verdict queued before draining
        while (i_valid) @(negedge i_clk);
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d byte transactions, %0d streams checked, %0d of them with an error",
                 n_accepted, n_streams, n_bad_streams);
        $display("idle phases: none, sender, receiver, both; one long receiver hold-off");
        if (n_fail == 0 && verdict_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/utf8v_pkg.sv
sv/utf8v_front.sv
sv/utf8v_queue.sv
sv/utf8v_back.sv
sv/utf8_stream_validator_top.sv
tb/tb_top.sv
